/* rtl/shl_pkg.sv */
`timescale 1ns / 1ps

package shl_pkg;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WIN_W   = 24;
  localparam int unsigned CAP_N   = 3;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 24'h0000ff;
  localparam logic [WIN_W-1:0] START_CODE   = 24'h000001;
  localparam logic [4:0]       NAL_TYPE_MASK = 5'h1f;
  localparam int unsigned      START_CODE_BYTES = 4;

  localparam logic [4:0] NAL_IDR = 5'd5;
  localparam logic [4:0] NAL_SPS = 5'd7;
  localparam logic [4:0] NAL_PPS = 5'd8;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPS   = 2'd1,
    ST_NO_PPS   = 2'd2,
    ST_TOO_LONG = 2'd3
  } shl_status_e;

  typedef struct packed {
    logic idr;
    logic pps;
    logic sps;
  } shl_found_t;

  typedef struct packed {
    logic       overflow;
    shl_found_t found;
  } shl_snap_flags_t;

  typedef logic [CAP_N-1:0][BYTE_W-1:0] shl_cap_t;

endpackage

/* rtl/shl_stream_if.sv */
`timescale 1ns / 1ps

interface shl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface shl_hdr_if;
  logic        valid;
  logic        ready;
  logic [15:0] sps_offset;
  logic [15:0] sps_length;
  logic [15:0] pps_offset;
  logic [15:0] pps_length;
  logic [7:0]  profile_code;
  logic [7:0]  profile_compat;
  logic [7:0]  level_code;
  logic [1:0]  status;

  modport source (
    output valid, output sps_offset, output sps_length, output pps_offset,
    output pps_length, output profile_code, output profile_compat,
    output level_code, output status, input ready
  );
  modport sink (
    input valid, input sps_offset, input sps_length, input pps_offset,
    input pps_length, input profile_code, input profile_compat,
    input level_code, input status, output ready
  );
endinterface

/* rtl/shl_scan.sv */
`timescale 1ns / 1ps

module shl_scan
  import shl_pkg::*;
#(
  parameter int unsigned POS_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [BYTE_W-1:0]   data_byte_i,
  input  logic                last_byte_i,
  output logic [POS_BITS-1:0] sps_start_o,
  output logic [POS_BITS-1:0] pps_start_o,
  output logic [POS_BITS-1:0] tail_o,
  output shl_snap_flags_t     flags_o,
  output shl_cap_t            cap_o
);

  logic [WIN_W-1:0]    window_q, window_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [POS_BITS-1:0] sps_start_q, sps_start_d;
  logic [POS_BITS-1:0] pps_start_q, pps_start_d;
  logic [POS_BITS-1:0] pps_end_q, pps_end_d;
  logic [POS_BITS-1:0] total;
  shl_found_t          found_q, found_d;
  logic                pending_q, pending_d;
  logic [1:0]          cap_idx_q, cap_idx_d;
  shl_cap_t            cap_q, cap_d;
  logic                ovf_q, ovf_d;
  logic [4:0]          nal;

  function automatic logic [POS_BITS-1:0] code_pos(input logic [POS_BITS-1:0] hdr);
    logic [POS_BITS-1:0] sc;
    sc = POS_BITS'(START_CODE_BYTES);
    code_pos = (hdr >= sc) ? hdr - sc : '0;
  endfunction

  always_comb begin
    window_d    = {window_q[WIN_W-BYTE_W-1:0], data_byte_i};
    sps_start_d = sps_start_q;
    pps_start_d = pps_start_q;
    pps_end_d   = pps_end_q;
    found_d     = found_q;
    cap_d       = cap_q;
    cap_idx_d   = cap_idx_q;
    pending_d   = 1'b0;
    ovf_d       = ovf_q;
    pos_d       = pos_q;
    nal         = data_byte_i[4:0] & NAL_TYPE_MASK;
    total       = pos_q + 1'b1;

    if (cap_idx_q != 2'd0) begin
      for (int k = 0; k < CAP_N; k++) begin
        if (cap_idx_q == 2'(k + 1)) cap_d[k] = data_byte_i;
      end
      cap_idx_d = (cap_idx_q == 2'(CAP_N)) ? 2'd0 : cap_idx_q + 2'd1;
    end

    if (pending_q) begin
      unique case (nal)
        NAL_SPS: begin
          sps_start_d = pos_q;
          found_d.sps = 1'b1;
          found_d.idr = 1'b0;
          cap_d       = '0;
          cap_idx_d   = 2'd1;
        end
        NAL_PPS: begin
          pps_start_d = pos_q;
          found_d.pps = 1'b1;
          found_d.idr = 1'b0;
        end
        NAL_IDR: begin
          if (!found_q.idr) begin
            pps_end_d   = code_pos(pos_q);
            found_d.idr = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (window_d == START_CODE) pending_d = 1'b1;

    if (pos_q == '1) begin
      ovf_d = 1'b1;
    end else begin
      pos_d = total;
    end
  end

  assign sps_start_o    = sps_start_d;
  assign pps_start_o    = pps_start_d;
  assign tail_o         = found_d.idr ? pps_end_d : total;
  assign flags_o.found  = found_d;
  assign flags_o.overflow = ovf_d;
  assign cap_o          = cap_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= WINDOW_RESET;
      pos_q       <= '0;
      sps_start_q <= '0;
      pps_start_q <= '0;
      pps_end_q   <= '0;
      found_q     <= '0;
      pending_q   <= 1'b0;
      cap_idx_q   <= 2'd0;
      cap_q       <= '0;
      ovf_q       <= 1'b0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        window_q    <= WINDOW_RESET;
        pos_q       <= '0;
        sps_start_q <= '0;
        pps_start_q <= '0;
        pps_end_q   <= '0;
        found_q     <= '0;
        pending_q   <= 1'b0;
        cap_idx_q   <= 2'd0;
        cap_q       <= '0;
        ovf_q       <= 1'b0;
      end else begin
        window_q    <= window_d;
        pos_q       <= pos_d;
        sps_start_q <= sps_start_d;
        pps_start_q <= pps_start_d;
        pps_end_q   <= pps_end_d;
        found_q     <= found_d;
        pending_q   <= pending_d;
        cap_idx_q   <= cap_idx_d;
        cap_q       <= cap_d;
        ovf_q       <= ovf_d;
      end
    end
  end

endmodule

/* rtl/h264_sequence_header_locator_top.sv */
`timescale 1ns / 1ps
// Channel  Dir  Fields                                             Transfer
// in_i     in   data_byte[7:0], last_byte                          valid & ready
// out_o    out  sps/pps offset+length[15:0], profile_code,          valid & ready
//               profile_compat, level_code[7:0], status[1:0]
// One byte per cycle while in_i.ready is high; the scan registers update on each
// byte transfer. After the last byte, the result passes through the snapshot
// register, then the output register. One result per packet, packets may follow
// back to back. in_i.ready drops only while both snapshot and output registers
// are full and out_o is stalled. Reset clears all scan state; no clearing pass.

module h264_sequence_header_locator_top
  import shl_pkg::*;
#(
  parameter int unsigned POS_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  shl_byte_if.sink     in_i,
  shl_hdr_if.source    out_o
);

  logic                accept;
  logic                adv_out;
  logic                snap_free;
  logic [POS_BITS-1:0] sps_start, pps_start, tail;
  shl_snap_flags_t     flags;
  shl_cap_t            cap;

  logic                snap_valid_q;
  logic [POS_BITS-1:0] snap_sps_q, snap_pps_q, snap_tail_q;
  shl_snap_flags_t     snap_flags_q;
  shl_cap_t            snap_cap_q;

  shl_status_e         status_d;
  logic [POS_BITS-1:0] sps_end, pps_stop;
  logic [POS_BITS-1:0] sps_code, pps_code;

  logic                out_valid_q;
  logic [FIELD_W-1:0]  sps_offset_q, sps_length_q, pps_offset_q, pps_length_q;
  shl_cap_t            out_cap_q;
  shl_status_e         status_q;

  function automatic logic [POS_BITS-1:0] code_pos(input logic [POS_BITS-1:0] hdr);
    logic [POS_BITS-1:0] sc;
    sc = POS_BITS'(START_CODE_BYTES);
    code_pos = (hdr >= sc) ? hdr - sc : '0;
  endfunction

  function automatic logic [POS_BITS-1:0] span(input logic [POS_BITS-1:0] e,
                                               input logic [POS_BITS-1:0] s);
    span = (e > s) ? e - s : '0;
  endfunction

  assign adv_out   = !out_valid_q || out_o.ready;
  assign snap_free = !snap_valid_q || adv_out;
  assign in_i.ready = snap_free;
  assign accept    = in_i.valid && snap_free;

  shl_scan #(
    .POS_BITS (POS_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (in_i.data_byte),
    .last_byte_i (in_i.last_byte),
    .sps_start_o (sps_start),
    .pps_start_o (pps_start),
    .tail_o      (tail),
    .flags_o     (flags),
    .cap_o       (cap)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (snap_free) begin
      snap_valid_q <= accept && in_i.last_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_i.last_byte) begin
      snap_sps_q   <= sps_start;
      snap_pps_q   <= pps_start;
      snap_tail_q  <= tail;
      snap_flags_q <= flags;
      snap_cap_q   <= cap;
    end
  end

  always_comb begin
    priority if (snap_flags_q.overflow) status_d = ST_TOO_LONG;
    else if (!snap_flags_q.found.sps)   status_d = ST_NO_SPS;
    else if (!snap_flags_q.found.pps)   status_d = ST_NO_PPS;
    else                                status_d = ST_OK;

    sps_code = code_pos(snap_sps_q);
    pps_code = code_pos(snap_pps_q);
    if (snap_pps_q > snap_sps_q) begin
      sps_end  = pps_code;
      pps_stop = snap_tail_q;
    end else begin
      sps_end  = snap_tail_q;
      pps_stop = sps_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_out) begin
      out_valid_q <= snap_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && snap_valid_q) begin
      status_q <= status_d;
      if (status_d == ST_OK) begin
        sps_offset_q <= FIELD_W'(sps_code);
        sps_length_q <= FIELD_W'(span(sps_end, snap_sps_q));
        pps_offset_q <= FIELD_W'(pps_code);
        pps_length_q <= FIELD_W'(span(pps_stop, snap_pps_q));
        out_cap_q    <= snap_cap_q;
      end else begin
        sps_offset_q <= '0;
        sps_length_q <= '0;
        pps_offset_q <= '0;
        pps_length_q <= '0;
        out_cap_q    <= '0;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.sps_offset     = sps_offset_q;
  assign out_o.sps_length     = sps_length_q;
  assign out_o.pps_offset     = pps_offset_q;
  assign out_o.pps_length     = pps_length_q;
  assign out_o.profile_code   = out_cap_q[0];
  assign out_o.profile_compat = out_cap_q[1];
  assign out_o.level_code     = out_cap_q[2];
  assign out_o.status         = status_q;

endmodule

/* rtl/shl_checker.sv */
`timescale 1ns / 1ps

module shl_checker
  import shl_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] sps_offset_i,
  input logic [15:0] sps_length_i,
  input logic [15:0] pps_offset_i,
  input logic [15:0] pps_length_i,
  input logic [7:0]  profile_code_i,
  input logic [7:0]  profile_compat_i,
  input logic [7:0]  level_code_i,
  input logic [1:0]  status_i
);

  // stalled result must hold; profile_compat is not among the checked fields
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
      $stable(sps_offset_i) && $stable(sps_length_i) && $stable(pps_offset_i) &&
      $stable(pps_length_i) && $stable(profile_code_i) && $stable(level_code_i))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_OK |->
      sps_offset_i == 16'd0 && sps_length_i == 16'd0 && pps_offset_i == 16'd0 &&
      pps_length_i == 16'd0 && profile_code_i == 8'd0 &&
      profile_compat_i == 8'd0 && level_code_i == 8'd0)
    else $error("error status with nonzero fields");

  a_rise_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_last_i, 2))
    else $error("result without a last-byte transfer");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output");

endmodule

bind h264_sequence_header_locator_top shl_checker u_shl_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_last_i        (in_i.last_byte),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .sps_offset_i     (out_o.sps_offset),
  .sps_length_i     (out_o.sps_length),
  .pps_offset_i     (out_o.pps_offset),
  .pps_length_i     (out_o.pps_length),
  .profile_code_i   (out_o.profile_code),
  .profile_compat_i (out_o.profile_compat),
  .level_code_i     (out_o.level_code),
  .status_i         (out_o.status)
);
